### design/ps2sa_pkg.sv
`timescale 1ns / 1ps

package ps2sa_pkg;

    // Scancode layout: bit 7 flags a key release, the low seven bits give the key.
    localparam int unsigned RELEASE_BIT = 7;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] TABLE_LEN   = 7'd58;

    // Outcome of translating one scancode byte.
    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
    } t_xlate;

    // Unshifted US layout, key codes 0x00 to 0x39.
    function automatic logic [6:0] plain_char(input logic [5:0] code);
        logic [6:0] c;
        unique case (code)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h31;
            6'd3:    c = 7'h32;
            6'd4:    c = 7'h33;
            6'd5:    c = 7'h34;
            6'd6:    c = 7'h35;
            6'd7:    c = 7'h36;
            6'd8:    c = 7'h37;
            6'd9:    c = 7'h38;
            6'd10:   c = 7'h39;
            6'd11:   c = 7'h30;
            6'd12:   c = 7'h2D;
            6'd13:   c = 7'h3D;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h71;
            6'd17:   c = 7'h77;
            6'd18:   c = 7'h65;
            6'd19:   c = 7'h72;
            6'd20:   c = 7'h74;
            6'd21:   c = 7'h79;
            6'd22:   c = 7'h75;
            6'd23:   c = 7'h69;
            6'd24:   c = 7'h6F;
            6'd25:   c = 7'h70;
            6'd26:   c = 7'h5B;
            6'd27:   c = 7'h5D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h61;
            6'd31:   c = 7'h73;
            6'd32:   c = 7'h64;
            6'd33:   c = 7'h66;
            6'd34:   c = 7'h67;
            6'd35:   c = 7'h68;
            6'd36:   c = 7'h6A;
            6'd37:   c = 7'h6B;
            6'd38:   c = 7'h6C;
            6'd39:   c = 7'h3B;
            6'd40:   c = 7'h27;
            6'd41:   c = 7'h60;
            6'd43:   c = 7'h5C;
            6'd44:   c = 7'h7A;
            6'd45:   c = 7'h78;
            6'd46:   c = 7'h63;
            6'd47:   c = 7'h76;
            6'd48:   c = 7'h62;
            6'd49:   c = 7'h6E;
            6'd50:   c = 7'h6D;
            6'd51:   c = 7'h2C;
            6'd52:   c = 7'h2E;
            6'd53:   c = 7'h2F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted US layout, key codes 0x00 to 0x39.
    function automatic logic [6:0] shifted_char(input logic [5:0] code);
        logic [6:0] c;
        unique case (code)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h21;
            6'd3:    c = 7'h40;
            6'd4:    c = 7'h23;
            6'd5:    c = 7'h24;
            6'd6:    c = 7'h25;
            6'd7:    c = 7'h5E;
            6'd8:    c = 7'h26;
            6'd9:    c = 7'h2A;
            6'd10:   c = 7'h28;
            6'd11:   c = 7'h29;
            6'd12:   c = 7'h5F;
            6'd13:   c = 7'h2B;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h51;
            6'd17:   c = 7'h57;
            6'd18:   c = 7'h45;
            6'd19:   c = 7'h52;
            6'd20:   c = 7'h54;
            6'd21:   c = 7'h59;
            6'd22:   c = 7'h55;
            6'd23:   c = 7'h49;
            6'd24:   c = 7'h4F;
            6'd25:   c = 7'h50;
            6'd26:   c = 7'h7B;
            6'd27:   c = 7'h7D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h41;
            6'd31:   c = 7'h53;
            6'd32:   c = 7'h44;
            6'd33:   c = 7'h46;
            6'd34:   c = 7'h47;
            6'd35:   c = 7'h48;
            6'd36:   c = 7'h4A;
            6'd37:   c = 7'h4B;
            6'd38:   c = 7'h4C;
            6'd39:   c = 7'h3A;
            6'd40:   c = 7'h22;
            6'd41:   c = 7'h7E;
            6'd43:   c = 7'h7C;
            6'd44:   c = 7'h5A;
            6'd45:   c = 7'h58;
            6'd46:   c = 7'h43;
            6'd47:   c = 7'h56;
            6'd48:   c = 7'h42;
            6'd49:   c = 7'h4E;
            6'd50:   c = 7'h4D;
            6'd51:   c = 7'h3C;
            6'd52:   c = 7'h3E;
            6'd53:   c = 7'h3F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

### design/ps2sa_xlate.sv
`timescale 1ns / 1ps

// Holds the shift flag and maps a make code through the layout tables.
module ps2sa_xlate (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_scan_byte,
    output ps2sa_pkg::t_xlate   o_xlate
);

    logic       r_shift_down;
    logic       n_shift_down;
    logic       release_key;
    logic [6:0] code;
    logic       is_shift;
    logic       in_table;
    logic [6:0] ch;

    assign release_key = i_scan_byte[ps2sa_pkg::RELEASE_BIT];
    assign code        = i_scan_byte[6:0];
    assign is_shift    = (code == ps2sa_pkg::CODE_LSHIFT) || (code == ps2sa_pkg::CODE_RSHIFT);
    assign in_table    = (code < ps2sa_pkg::TABLE_LEN);

    always_comb begin
        ch = r_shift_down ? ps2sa_pkg::shifted_char(code[5:0])
                          : ps2sa_pkg::plain_char(code[5:0]);
        o_xlate.ch    = ch;
        o_xlate.valid = !release_key && !is_shift && in_table && (ch != 7'h00);
        n_shift_down  = (i_en && is_shift) ? !release_key : r_shift_down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_down <= 1'b0;
        end else begin
            r_shift_down <= n_shift_down;
        end
    end

endmodule

### design/ps2_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps

// A result passes through stage one and the output register on its way to the output.
// Throughput: one transaction per cycle unless stalled, bounded by the memory's single port.
// A read pops through that memory, whose registered data forms the first pipeline stage.
// Reset (synchronous, active low) clears the shift flag, both FIFO pointers and the
// pipeline valids; the character memory keeps its contents and needs no clearing.
module ps2_scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [7:0] i_scan_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_echo_valid,
    output logic [6:0] o_echo_char,
    output logic       o_dropped,
    output logic       o_read_valid,
    output logic [6:0] o_read_char,
    output logic       o_char_waiting
);

    // Pointer width follows the ring size; the ring holds FIFO_DEPTH-1 characters.
    localparam int PW = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    // Handshake and pipeline control. Stage one holds the memory read; the output
    // register behind it lets a new transaction enter while a result waits.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_free;
    logic accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign accept     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // Translation of scancode transactions.
    ps2sa_pkg::t_xlate xlate;

    ps2sa_xlate u_xlate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept && !i_func),
        .i_scan_byte (i_scan_byte),
        .o_xlate     (xlate)
    );

    // FIFO pointers. Full and empty are judged against the pointers as they stand
    // when the transaction is accepted, at most one transaction per cycle.
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;
    logic          fifo_full;
    logic          fifo_empty;
    logic          push;
    logic          pop;
    logic          want_char;

    assign wp_inc     = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc     = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign fifo_full  = (wp_inc == r_rp);
    assign fifo_empty = (r_wp == r_rp);
    assign want_char  = accept && !i_func && xlate.valid;
    assign push       = want_char && !fifo_full;
    assign pop        = accept && i_func && !fifo_empty;

    always_comb begin
        n_wp = push ? wp_inc : r_wp;
        n_rp = pop ? rp_inc : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // Character memory: one write or one read per cycle, registered read data.
    // An entry is only read after the cycle in which it was written, so no
    // forwarding is needed between a push and a later pop of the same entry.
    logic [6:0] r_mem [FIFO_DEPTH];
    logic [6:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= xlate.ch;
        end
        if (pop) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // Stage one: side information of the transaction whose memory read is in flight.
    logic       r_s1_echo_valid;
    logic [6:0] r_s1_echo_char;
    logic       r_s1_dropped;
    logic       r_s1_read_valid;
    logic       r_s1_waiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_echo_valid <= want_char;
            r_s1_echo_char  <= want_char ? xlate.ch : 7'h00;
            r_s1_dropped    <= want_char && fifo_full;
            r_s1_read_valid <= pop;
            r_s1_waiting    <= (n_wp != n_rp);
        end
    end

    // Output register.
    logic       r_out_echo_valid;
    logic [6:0] r_out_echo_char;
    logic       r_out_dropped;
    logic       r_out_read_valid;
    logic [6:0] r_out_read_char;
    logic       r_out_waiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_echo_valid <= r_s1_echo_valid;
            r_out_echo_char  <= r_s1_echo_char;
            r_out_dropped    <= r_s1_dropped;
            r_out_read_valid <= r_s1_read_valid;
            r_out_read_char  <= r_s1_read_valid ? r_rd_data : 7'h00;
            r_out_waiting    <= r_s1_waiting;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_echo_valid   = r_out_echo_valid;
    assign o_echo_char    = r_out_echo_char;
    assign o_dropped      = r_out_dropped;
    assign o_read_valid   = r_out_read_valid;
    assign o_read_char    = r_out_read_char;
    assign o_char_waiting = r_out_waiting;

    // A character can only be dropped if it was also echoed.
    a_drop_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> o_echo_valid)
        else $error("dropped flagged without an echoed character");

    // A transaction is either a scancode or a read, never both.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_echo_valid && o_read_valid))
        else $error("echo and read reported in the same result");

    // Both pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= PTR_LAST) && (r_rp <= PTR_LAST))
        else $error("FIFO pointer outside the ring");

    // While stage one is blocked, the memory read data it depends on holds.
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> $stable(r_rd_data))
        else $error("memory read data changed under a stalled stage");

    // A push never coincides with a pop.
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && pop))
        else $error("memory written and read in the same cycle");

endmodule

### sim/ps2_scancode_to_ascii_fifo_tb.sv
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_fifo_tb;

    // The ring in the block keeps one slot free, so it buffers RING_SLOTS-1 characters.
    localparam int RING_SLOTS = 256;

    // Operation selected by i_func.
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Make and break codes of both shift keys.
    localparam logic [7:0] LSHIFT_MAKE  = {1'b0, ps2sa_pkg::CODE_LSHIFT};
    localparam logic [7:0] LSHIFT_BREAK = {1'b1, ps2sa_pkg::CODE_LSHIFT};
    localparam logic [7:0] RSHIFT_MAKE  = {1'b0, ps2sa_pkg::CODE_RSHIFT};
    localparam logic [7:0] RSHIFT_BREAK = {1'b1, ps2sa_pkg::CODE_RSHIFT};

    // One pending transaction on the input side. Each one carries the idling
    // behaviour of its phase, so that both sides change pace as the stimulus moves on.
    typedef struct {
        logic       func;
        logic [7:0] scan;
        int         idle_pct;
        int         stall_pct;
        bit         wait_drain;
    } t_keystroke;

    // What the block should report for one accepted transaction.
    typedef struct packed {
        logic       echo_valid;
        logic [6:0] echo_char;
        logic       dropped;
        logic       read_valid;
        logic [6:0] read_char;
        logic       char_waiting;
    } t_key_result;

    // US layout for key codes 0x00 to 0x39, without and with shift held.
    // A zero entry means the key produces no character.
    logic [6:0] plain_keys [0:57] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
        7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
        7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };
    logic [6:0] upper_keys [0:57] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
        7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
        7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Idling phases, rotated every PHASE_LEN transactions: none, sender idle,
    // receiver stalling, and both sides at once.
    localparam int PHASE_LEN = 40;
    int send_idle_by_phase [4] = '{0, 71, 0, 32};
    int recv_stall_by_phase[4] = '{0, 0, 71, 32};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_func = FUNC_SCAN;
    logic [7:0] i_scan_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_echo_valid;
    logic [6:0] o_echo_char;
    logic       o_dropped;
    logic       o_read_valid;
    logic [6:0] o_read_char;
    logic       o_char_waiting;

    // Shadow copy of the keyboard state: shift flag, character ring and its pointers.
    logic       model_shift = 1'b0;
    logic [6:0] ascii_ring [RING_SLOTS];
    int         wr_idx = 0;
    int         rd_idx = 0;

    t_keystroke  keys_pending[$];
    t_key_result results_due[$];
    int          items_queued = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;

    ps2_scancode_to_ascii_fifo #(
        .FIFO_DEPTH(RING_SLOTS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_scan_byte    (i_scan_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_echo_valid   (o_echo_valid),
        .o_echo_char    (o_echo_char),
        .o_dropped      (o_dropped),
        .o_read_valid   (o_read_valid),
        .o_read_char    (o_read_char),
        .o_char_waiting (o_char_waiting)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the result of one accepted transaction and updates the shadow
    // state. Shift make and break codes only move the shift flag; any other break
    // code, a key code beyond the table or a blank table entry yields nothing.
    // A character that finds the ring full is still echoed but flagged as dropped.
    task automatic translate_key_step(input logic func, input logic [7:0] sb);
        t_key_result r;
        logic [6:0]  code;
        logic [6:0]  ch;
        int          nxt;
        r = '0;
        code = sb[6:0];
        if (func == FUNC_SCAN) begin
            if (code == ps2sa_pkg::CODE_LSHIFT || code == ps2sa_pkg::CODE_RSHIFT) begin
                model_shift = !sb[ps2sa_pkg::RELEASE_BIT];
            end else if (!sb[ps2sa_pkg::RELEASE_BIT] && code < ps2sa_pkg::TABLE_LEN) begin
                ch = model_shift ? upper_keys[code] : plain_keys[code];
                if (ch != 7'h00) begin
                    nxt = (wr_idx + 1) % RING_SLOTS;
                    r.echo_valid = 1'b1;
                    r.echo_char = ch;
                    if (nxt != rd_idx) begin
                        ascii_ring[wr_idx] = ch;
                        wr_idx = nxt;
                    end else begin
                        r.dropped = 1'b1;
                    end
                end
            end
        end else if (wr_idx != rd_idx) begin
            // A read on an empty ring reports nothing and leaves everything alone.
            r.read_valid = 1'b1;
            r.read_char = ascii_ring[rd_idx];
            rd_idx = (rd_idx + 1) % RING_SLOTS;
        end
        r.char_waiting = (wr_idx != rd_idx);
        results_due.push_back(r);
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Appends one transaction, tagged with the idling of the phase it falls in.
    task automatic queue_item(input logic func, input logic [7:0] sb, input bit wait_drain);
        t_keystroke k;
        int         ph;
        ph = (items_queued / PHASE_LEN) % 4;
        k.func = func;
        k.scan = sb;
        k.idle_pct = send_idle_by_phase[ph];
        k.stall_pct = recv_stall_by_phase[ph];
        k.wait_drain = wait_drain;
        keys_pending.push_back(k);
        items_queued++;
    endtask

    // A mixture of ordinary typing and noise: reads, shift presses and releases,
    // table keys, stray break codes and wholly random bytes.
    task automatic queue_typing(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 25) begin
                queue_item(FUNC_READ, 8'($urandom_range(255)), 1'b0);
            end else if (r < 35) begin
                case ($urandom_range(3))
                    0:       queue_item(FUNC_SCAN, LSHIFT_MAKE, 1'b0);
                    1:       queue_item(FUNC_SCAN, LSHIFT_BREAK, 1'b0);
                    2:       queue_item(FUNC_SCAN, RSHIFT_MAKE, 1'b0);
                    default: queue_item(FUNC_SCAN, RSHIFT_BREAK, 1'b0);
                endcase
            end else if (r < 75) begin
                queue_item(FUNC_SCAN, 8'($urandom_range(57)), 1'b0);
            end else if (r < 85) begin
                queue_item(FUNC_SCAN, 8'h80 | 8'($urandom_range(127)), 1'b0);
            end else begin
                queue_item(FUNC_SCAN, 8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    // Driver. A new transaction is offered only when the previous one has gone,
    // so a stalled payload never changes. The predictor runs at the edge where
    // the block takes the transaction.
    always @(posedge i_clk) begin : feed_keystrokes
        t_keystroke nxt_key;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_func <= FUNC_SCAN;
            i_scan_byte <= 8'h00;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                translate_key_step(i_func, i_scan_byte);
            end
            if (!i_in_valid || !o_in_stall) begin
                // A transaction flagged wait_drain is held back until every
                // outstanding result has been collected.
                if (keys_pending.size() != 0
                    && !(keys_pending[0].wait_drain && results_due.size() != 0)
                    && $urandom_range(99) >= keys_pending[0].idle_pct) begin
                    nxt_key = keys_pending.pop_front();
                    recv_stall_pct = nxt_key.stall_pct;
                    i_in_valid <= 1'b1;
                    i_func <= nxt_key.func;
                    i_scan_byte <= nxt_key.scan;
                end else begin
                    // While idle the payload wanders, since it should be ignored.
                    i_in_valid <= 1'b0;
                    i_func <= 1'($urandom_range(1));
                    i_scan_byte <= 8'($urandom_range(255));
                end
            end
        end
    end

    // Monitor. Every result taken from the block is matched against the oldest
    // prediction; the stall is redrawn each cycle from the current phase.
    always @(posedge i_clk) begin : collect_results
        t_key_result due;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display(
                        "%0t: result with none outstanding, expected nothing, got %b%h%b%b%h%b",
                        $time, o_echo_valid, o_echo_char, o_dropped, o_read_valid,
                        o_read_char, o_char_waiting);
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    compare_field("echo_valid", 8'(due.echo_valid), 8'(o_echo_valid));
                    compare_field("echo_char", 8'(due.echo_char), 8'(o_echo_char));
                    compare_field("dropped", 8'(due.dropped), 8'(o_dropped));
                    compare_field("read_valid", 8'(due.read_valid), 8'(o_read_valid));
                    compare_field("read_char", 8'(due.read_char), 8'(o_read_char));
                    compare_field("char_waiting", 8'(due.char_waiting), 8'(o_char_waiting));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        // Directed opening: a read on the empty ring, plain keys at both ends of
        // the table, blank entries, codes beyond the table, ignored break codes,
        // both shift keys, and reads that take characters back out of the ring.
        queue_item(FUNC_READ, 8'hFF, 1'b0);
        queue_item(FUNC_SCAN, 8'h1E, 1'b0);
        queue_item(FUNC_SCAN, 8'h9E, 1'b0);
        queue_item(FUNC_SCAN, 8'h00, 1'b0);
        queue_item(FUNC_SCAN, 8'h01, 1'b0);
        queue_item(FUNC_SCAN, 8'h39, 1'b0);
        queue_item(FUNC_SCAN, 8'h3A, 1'b0);
        queue_item(FUNC_SCAN, 8'h7F, 1'b0);
        queue_item(FUNC_SCAN, 8'hFF, 1'b0);
        queue_item(FUNC_SCAN, 8'h80, 1'b0);
        queue_item(FUNC_SCAN, 8'h1D, 1'b0);
        queue_item(FUNC_SCAN, LSHIFT_MAKE, 1'b0);
        queue_item(FUNC_SCAN, 8'h02, 1'b0);
        queue_item(FUNC_SCAN, 8'h29, 1'b0);
        queue_item(FUNC_SCAN, LSHIFT_BREAK, 1'b0);
        queue_item(FUNC_SCAN, 8'h02, 1'b0);
        queue_item(FUNC_SCAN, RSHIFT_MAKE, 1'b0);
        queue_item(FUNC_SCAN, 8'h10, 1'b0);
        queue_item(FUNC_SCAN, 8'h37, 1'b0);
        queue_item(FUNC_SCAN, RSHIFT_BREAK, 1'b0);
        queue_item(FUNC_SCAN, 8'h1C, 1'b0);
        for (int n = 0; n < 4; n++) begin
            queue_item(FUNC_READ, 8'($urandom_range(255)), 1'b0);
        end

        queue_typing(120);

        // Flood the ring with characters and no reads, so that it fills and later
        // keystrokes are echoed but dropped. Letter keys keep nearly every
        // transaction productive; a few shift toggles and stray codes are mixed in.
        for (int n = 0; n < 300; n++) begin
            case ($urandom_range(9))
                0:       queue_item(FUNC_SCAN, $urandom_range(1) ? LSHIFT_MAKE
                                                                 : RSHIFT_BREAK, 1'b0);
                1:       queue_item(FUNC_SCAN, 8'($urandom_range(127)), 1'b0);
                default: queue_item(FUNC_SCAN, 8'($urandom_range(16, 25)), 1'b0);
            endcase
        end

        // Drain it again once the flood has fully emerged, with a few reads to spare.
        queue_item(FUNC_READ, 8'($urandom_range(255)), 1'b1);
        for (int n = 0; n < 269; n++) begin
            queue_item(FUNC_READ, 8'($urandom_range(255)), 1'b0);
        end

        queue_item(FUNC_SCAN, 8'($urandom_range(57)), 1'b1);
        queue_typing(60);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampling on the falling edge keeps this check clear of the updates
        // made at the rising edge.
        while (keys_pending.size() != 0 || i_in_valid || results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("[ps2_scancode_to_ascii_fifo] OK");
        end else begin
            $display("[ps2_scancode_to_ascii_fifo] ERROR");
        end
        $finish;
    end

    // Backstop in case the block hangs or loses a result.
    initial begin
        #5000000;
        $display("[ps2_scancode_to_ascii_fifo] ERROR");
        $finish;
    end

endmodule
